// ===== sv/sce_pkg.sv =====
// ============================================================================
// sce_pkg
// Shared types, codes and constants of the execute unit: operation codes,
// decoded instruction, execute stage payload and result layout.
// ============================================================================
package sce_pkg;

  // Word and store geometry.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned MEM_WORDS = 8192;
  localparam int unsigned MEM_AW    = 13;
  localparam int unsigned FUNC_W    = 4;

  // Stream widths: fields packed from bit 0 up, filled to whole bytes.
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USER_W = 2;

  // Instruction function codes as they arrive on the input stream.
  localparam logic [FUNC_W-1:0] FUNC_ADD       = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB       = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL       = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_REL  = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_STORE_REL = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_ABS  = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_STORE_ABS = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_BNE       = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_JAL       = 4'd8;

  // Words preloaded into data memory after reset; the last one listed wins.
  localparam logic [MEM_AW-1:0] PRELOAD_A_ADDR = MEM_AW'(4096 % MEM_WORDS);
  localparam logic [MEM_AW-1:0] PRELOAD_B_ADDR = MEM_AW'(4100 % MEM_WORDS);
  localparam logic [MEM_AW-1:0] PRELOAD_C_ADDR = MEM_AW'(5 % MEM_WORDS);
  localparam logic [DATA_W-1:0] PRELOAD_A_VAL  = 32'd10;
  localparam logic [DATA_W-1:0] PRELOAD_B_VAL  = 32'd20;
  localparam logic [DATA_W-1:0] PRELOAD_C_VAL  = 32'd10;

  // Operation class after decode.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_LOAD,
    OP_STORE,
    OP_BNE,
    OP_JAL,
    OP_NOP
  } op_e;

  // Decoded instruction carried from the front end through the queue.
  typedef struct packed {
    op_e               op;
    logic              abs_mode;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [DATA_W-1:0] imm;
    logic [MEM_AW-1:0] abs_addr;
  } sce_item_t;

  // Payload of the memory/writeback stage.
  typedef struct packed {
    logic              rw;
    logic              mw;
    logic              memop;
    logic              load;
    logic              mul;
    logic [REG_AW-1:0] rd;
    logic [DATA_W-1:0] alu;
    logic [MEM_AW-1:0] maddr;
    logic [DATA_W-1:0] sdata;
    logic [DATA_W-1:0] pc;
  } sce_ex_t;

  // One result item.
  typedef struct packed {
    logic [DATA_W-1:0] pc;
    logic              rw;
    logic [REG_AW-1:0] widx;
    logic [DATA_W-1:0] wval;
    logic              mw;
    logic [MEM_AW-1:0] maddr;
    logic [DATA_W-1:0] mval;
  } sce_res_t;

  // Request from the pipeline to the data memory.
  typedef struct packed {
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } sce_mem_req_t;

  // Value of a memory word right after reset.
  function automatic logic [DATA_W-1:0] mem_init_word(input logic [MEM_AW-1:0] addr);
    logic [DATA_W-1:0] val;
    val = '0;
    if (addr == PRELOAD_C_ADDR) begin
      val = PRELOAD_C_VAL;
    end else if (addr == PRELOAD_B_ADDR) begin
      val = PRELOAD_B_VAL;
    end else if (addr == PRELOAD_A_ADDR) begin
      val = PRELOAD_A_VAL;
    end
    return val;
  endfunction

endpackage

// ===== sv/simple_cpu_execute_unit_core.sv =====
// ============================================================================
// simple_cpu_execute_unit_core
// Execute unit with register file, program counter and data memory. A front
// end decodes instruction beats into a short queue; a pipelined back end
// executes them and returns one result beat per instruction.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: func; tdata: dest_reg, src_reg_a, src_reg_b,
//                      immediate, abs_address
// m_axis    out        tuser: reg_written, mem_written; tdata: pc_value,
//                      written_index, written_value, mem_address, mem_value
//
// Throughput is one instruction per cycle unless the output stalls; register
// and memory results are forwarded to the following instruction, so no
// dependency inserts a bubble. A beat passes the front holding register, the
// queue, then the register read, memory/writeback and output registers. After
// reset the data memory clears all 8192 words, one word per cycle through its
// single write port; s_axis_tready_o stays low until it ends. A stalled output
// freezes the back end; the front end keeps taking beats until the queue is full.
// ============================================================================
module simple_cpu_execute_unit_core import sce_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [4:0] dest_reg, [9:5] src_reg_a, [14:10] src_reg_b, [46:15] immediate,
  // [59:47] abs_address, [63:60] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [3:0] func
  input  logic [FUNC_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [31:0] pc_value, [36:32] written_index, [68:37] written_value,
  // [81:69] mem_address, [113:82] mem_value, [127:114] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] reg_written, [1] mem_written
  output logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  logic      busy;
  logic      push;
  logic      q_ready;
  logic      q_valid;
  logic      pop;
  sce_item_t f_item;
  sce_item_t q_item;
  sce_res_t  res;

  sce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_i     (busy),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .push_o     (push),
    .item_o     (f_item),
    .q_ready_i  (q_ready)
  );

  sce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  sce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .busy_o     (busy),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_res_o    (res)
  );

  // Pack the result beat.
  assign m_axis_tdata_o = {14'd0, res.mval, res.maddr, res.wval, res.widx, res.pc};
  assign m_axis_tuser_o = {res.mw, res.rw};

endmodule

// ===== sv/sce_front.sv =====
// ============================================================================
// sce_front
// Input side: accepts instruction beats, decodes the function code into an
// operation class and hands the decoded instruction to the queue.
// ============================================================================
module sce_front import sce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 busy_i,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [IN_DATA_W-1:0] s_tdata_i,
  input  logic [FUNC_W-1:0]    s_tuser_i,
  output logic                 push_o,
  output sce_item_t            item_o,
  input  logic                 q_ready_i
);

  logic      f_valid_q;
  sce_item_t f_item_q;
  sce_item_t dec_item;
  logic      accept;

  // Decode the function code and unpack the operand fields.
  always_comb begin
    dec_item          = '0;
    dec_item.op       = OP_NOP;
    dec_item.rd       = s_tdata_i[4:0];
    dec_item.ra       = s_tdata_i[9:5];
    dec_item.rb       = s_tdata_i[14:10];
    dec_item.imm      = s_tdata_i[46:15];
    dec_item.abs_addr = s_tdata_i[59:47];
    unique case (s_tuser_i)
      FUNC_ADD:       dec_item.op = OP_ADD;
      FUNC_SUB:       dec_item.op = OP_SUB;
      FUNC_MUL:       dec_item.op = OP_MUL;
      FUNC_LOAD_REL:  dec_item.op = OP_LOAD;
      FUNC_STORE_REL: dec_item.op = OP_STORE;
      FUNC_LOAD_ABS: begin
        dec_item.op       = OP_LOAD;
        dec_item.abs_mode = 1'b1;
      end
      FUNC_STORE_ABS: begin
        dec_item.op       = OP_STORE;
        dec_item.abs_mode = 1'b1;
      end
      FUNC_BNE:       dec_item.op = OP_BNE;
      FUNC_JAL:       dec_item.op = OP_JAL;
      default:        dec_item.op = OP_NOP;
    endcase
  end

  // One holding register in front of the queue.
  assign s_tready_o = !busy_i && (!f_valid_q || q_ready_i);
  assign accept     = s_tvalid_i && s_tready_o;
  assign push_o     = f_valid_q && q_ready_i;
  assign item_o     = f_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (accept) begin
      f_valid_q <= 1'b1;
    end else if (push_o) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q <= dec_item;
    end
  end

endmodule

// ===== sv/sce_queue.sv =====
// ============================================================================
// sce_queue
// Short FIFO of decoded instructions between the front end and the
// execute pipeline.
// ============================================================================
module sce_queue import sce_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sce_item_t item_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output sce_item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sce_item_t        slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign ready_o = (count_q != FULL_CNT);
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // The fill level never goes past the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("queue fill level exceeds depth");

  // Nothing is taken from an empty queue, nothing written into a full one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(pop_i && !valid_o) && !(push_i && !ready_o))
    else $error("queue overrun or underrun");

  // An empty queue has its pointers together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("queue pointers disagree with fill level");

endmodule

// ===== sv/sce_dmem.sv =====
// ============================================================================
// sce_dmem
// Word-addressed data memory: one write and one registered read per cycle,
// same-cycle write-to-read bypass, and a clearing pass after reset that
// writes the reset image one word per cycle.
// ============================================================================
module sce_dmem import sce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sce_mem_req_t      req_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              busy_o
);

  localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(MEM_WORDS - 1);

  logic [DATA_W-1:0] mem_q [MEM_WORDS];
  logic [DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0] byp_data_q;
  logic              byp_q;
  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_addr_q;
  logic              wr_en;
  logic [MEM_AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Write port is owned by the clearing pass until it is done.
  assign wr_en   = clr_busy_q || req_i.wr_en;
  assign wr_addr = clr_busy_q ? clr_addr_q : req_i.wr_addr;
  assign wr_data = clr_busy_q ? mem_init_word(clr_addr_q) : req_i.wr_data;
  assign busy_o  = clr_busy_q;

  // Clearing pass sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_ADDR) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Memory array write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Registered read; a store landing on the same word in the same cycle wins.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q  <= mem_q[req_i.rd_addr];
      byp_q      <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr);
      byp_data_q <= req_i.wr_data;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_data_q;

endmodule

// ===== sv/sce_back.sv =====
// ============================================================================
// sce_back
// Execute pipeline: register read, execute (ALU, multiplier, address, branch),
// memory/writeback and the output register. Holds the register file, the
// program counter and the data memory.
// ============================================================================
module sce_back import sce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  sce_item_t             q_item_i,
  output logic                  pop_o,
  output logic                  busy_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output sce_res_t              m_res_o
);

  // Pipeline control and payload.
  logic              adv;
  logic              s1_valid_q;
  sce_item_t         s1_q;
  logic              s2_valid_q;
  sce_ex_t           s2_q;
  logic [DATA_W-1:0] prod_q;
  logic              s3_valid_q;
  sce_res_t          s3_q;
  logic [DATA_W-1:0] pc_q;

  // Register file.
  logic [DATA_W-1:0]    rf_mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid_q;
  logic [DATA_W-1:0]    rfa_q;
  logic [DATA_W-1:0]    rfb_q;

  // Data memory interface.
  sce_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rd_data;
  logic              mem_busy;

  // Execute and writeback signals.
  logic              commit;
  logic              rf_we;
  logic [DATA_W-1:0] s2_wval;
  logic [DATA_W-1:0] va;
  logic [DATA_W-1:0] vb;
  logic [DATA_W-1:0] pc_next;
  sce_ex_t           ex_d;
  sce_res_t          res_d;

  // The whole pipeline moves when the output register can take a beat.
  assign adv    = !s3_valid_q || m_tready_i;
  assign pop_o  = adv && q_valid_i;
  assign commit = adv && s2_valid_q;
  assign busy_o = mem_busy;

  // Writeback value of the instruction in the memory stage.
  always_comb begin
    if (s2_q.load) begin
      s2_wval = mem_rd_data;
    end else if (s2_q.mul) begin
      s2_wval = prod_q;
    end else begin
      s2_wval = s2_q.alu;
    end
  end

  assign rf_we = commit && s2_q.rw;

  // Register file: two registered read ports with write bypass, valid bits
  // stand in for the reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (rf_we) begin
      rf_valid_q[s2_q.rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem_q[s2_q.rd] <= s2_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (rf_we && (s2_q.rd == q_item_i.ra)) begin
        rfa_q <= s2_wval;
      end else begin
        rfa_q <= rf_valid_q[q_item_i.ra] ? rf_mem_q[q_item_i.ra] : '0;
      end
      if (rf_we && (s2_q.rd == q_item_i.rb)) begin
        rfb_q <= s2_wval;
      end else begin
        rfb_q <= rf_valid_q[q_item_i.rb] ? rf_mem_q[q_item_i.rb] : '0;
      end
    end
  end

  // Operands, forwarded from the instruction just ahead.
  assign va = (s2_valid_q && s2_q.rw && (s2_q.rd == s1_q.ra)) ? s2_wval : rfa_q;
  assign vb = (s2_valid_q && s2_q.rw && (s2_q.rd == s1_q.rb)) ? s2_wval : rfb_q;

  // Execute stage.
  always_comb begin
    ex_d       = '0;
    ex_d.rd    = s1_q.rd;
    ex_d.maddr = s1_q.abs_mode ? s1_q.abs_addr : (va[MEM_AW-1:0] + s1_q.imm[MEM_AW-1:0]);
    ex_d.sdata = s1_q.abs_mode ? va : vb;
    pc_next    = pc_q;
    unique case (s1_q.op)
      OP_ADD: begin
        ex_d.rw  = 1'b1;
        ex_d.alu = va + vb;
      end
      OP_SUB: begin
        ex_d.rw  = 1'b1;
        ex_d.alu = va - vb;
      end
      OP_MUL: begin
        ex_d.rw  = 1'b1;
        ex_d.mul = 1'b1;
      end
      OP_LOAD: begin
        ex_d.rw    = 1'b1;
        ex_d.load  = 1'b1;
        ex_d.memop = 1'b1;
      end
      OP_STORE: begin
        ex_d.mw    = 1'b1;
        ex_d.memop = 1'b1;
      end
      OP_BNE: begin
        if (va != vb) begin
          pc_next = pc_q + s1_q.imm;
        end
      end
      OP_JAL: begin
        ex_d.rw  = 1'b1;
        ex_d.alu = pc_q;
        pc_next  = pc_q + s1_q.imm;
      end
      default: begin
        pc_next = pc_q;
      end
    endcase
    ex_d.pc = pc_next;
  end

  // Memory port: loads read from the execute stage, stores commit from the
  // memory stage.
  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = adv;
    mem_req.rd_addr = ex_d.maddr;
    mem_req.wr_en   = commit && s2_q.mw;
    mem_req.wr_addr = s2_q.maddr;
    mem_req.wr_data = s2_q.sdata;
  end

  sce_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data),
    .busy_o    (mem_busy)
  );

  // Result fields; fields of an effect that did not happen read as zero.
  always_comb begin
    res_d       = '0;
    res_d.pc    = s2_q.pc;
    res_d.rw    = s2_q.rw;
    res_d.mw    = s2_q.mw;
    if (s2_q.rw) begin
      res_d.widx = s2_q.rd;
      res_d.wval = s2_wval;
    end
    if (s2_q.memop) begin
      res_d.maddr = s2_q.maddr;
      res_d.mval  = s2_q.load ? mem_rd_data : s2_q.sdata;
    end
  end

  // Stage valid bits and the program counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      pc_q       <= '0;
    end else if (adv) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (s1_valid_q) begin
        pc_q <= pc_next;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= q_item_i;
      s2_q   <= ex_d;
      prod_q <= va * vb;
      s3_q   <= res_d;
    end
  end

  assign m_tvalid_o = s3_valid_q;
  assign m_res_o    = s3_q;

  // No instruction reaches the memory stage while memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !s2_valid_q)
    else $error("instruction in flight during memory clearing pass");

  // The pc moves only when an instruction leaves the execute stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(adv && s1_valid_q) |=> $stable(pc_q))
    else $error("pc changed without an executed instruction");

  // A register write marks its entry as holding data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rf_we |=> rf_valid_q[$past(s2_q.rd)])
    else $error("register write lost its valid bit");

endmodule

// ===== tb/sv/simple_cpu_execute_unit_core_test.sv =====
// ============================================================================
// simple_cpu_execute_unit_core_test
// Self-checking bench for the execute unit. A short table of directed
// instructions is followed by constrained-by-hand random traffic. Every
// accepted instruction beat is run through a local model of the register
// file, pc and data memory, and each result beat is compared field by field
// against the oldest expected result. Sender bursts, receiver stalls, one
// long output hold-off and one full drain are all exercised.
// ============================================================================
module simple_cpu_execute_unit_core_test;
  import sce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes with no package name: the plain no-op and the top of the unused range.
  localparam logic [FUNC_W-1:0] FUNC_NOP      = 4'd9;
  localparam logic [FUNC_W-1:0] FUNC_LAST_ILL = 4'd15;

  localparam int N_RANDOM      = 1926;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_BURST    = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_AT      = 1300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int END_WAIT      = 20000;
  localparam int MAX_PRINTS    = 40;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  // One decoded instruction as driven on the input stream.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [DATA_W-1:0] imm;
    logic [MEM_AW-1:0] absa;
  } instr_t;

  // A row of the directed table; res is used only when typed is set.
  typedef struct packed {
    instr_t   ins;
    logic     typed;
    sce_res_t res;
  } dir_row_t;

  // Hand-written expectation travelling alongside an offered beat.
  typedef struct packed {
    logic     typed;
    sce_res_t res;
  } typed_slot_t;

  localparam sce_res_t RES_NONE = '0;
  localparam int N_DIR = 24;

  // Field order of ins: func, rd, ra, rb, imm, absa.
  // Field order of res: pc, rw, widx, wval, mw, maddr, mval.
  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    // Right after reset: no-op and the top unused code report only the pc.
    '{'{FUNC_NOP, 5'd0, 5'd0, 5'd0, 32'd0, 13'd0}, 1'b1, RES_NONE},
    '{'{FUNC_LAST_ILL, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 13'd8191}, 1'b1, RES_NONE},
    // Preloaded words and the memory ends.
    '{'{FUNC_LOAD_ABS, 5'd1, 5'd0, 5'd0, 32'd0, 13'd4096}, 1'b1,
      '{32'd0, 1'b1, 5'd1, 32'd10, 1'b0, 13'd4096, 32'd10}},
    '{'{FUNC_LOAD_ABS, 5'd2, 5'd0, 5'd0, 32'd0, 13'd4100}, 1'b1,
      '{32'd0, 1'b1, 5'd2, 32'd20, 1'b0, 13'd4100, 32'd20}},
    '{'{FUNC_LOAD_ABS, 5'd3, 5'd0, 5'd0, 32'd0, 13'd5}, 1'b1,
      '{32'd0, 1'b1, 5'd3, 32'd10, 1'b0, 13'd5, 32'd10}},
    '{'{FUNC_LOAD_ABS, 5'd31, 5'd0, 5'd0, 32'd0, 13'd8191}, 1'b1,
      '{32'd0, 1'b1, 5'd31, 32'd0, 1'b0, 13'd8191, 32'd0}},
    '{'{FUNC_LOAD_ABS, 5'd4, 5'd0, 5'd0, 32'd0, 13'd0}, 1'b1,
      '{32'd0, 1'b1, 5'd4, 32'd0, 1'b0, 13'd0, 32'd0}},
    // Arithmetic on back-to-back dependent registers.
    '{'{FUNC_ADD, 5'd5, 5'd1, 5'd2, 32'd0, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_SUB, 5'd6, 5'd3, 5'd2, 32'd0, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_MUL, 5'd7, 5'd6, 5'd6, 32'd0, 13'd0}, 1'b0, RES_NONE},
    // Relative addresses that wrap past 2^31 and the memory size.
    '{'{FUNC_STORE_REL, 5'd0, 5'd1, 5'd2, 32'h7FFF_FFFF, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_LOAD_REL, 5'd10, 5'd1, 5'd0, 32'h7FFF_FFFF, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_LOAD_REL, 5'd11, 5'd1, 5'd0, 32'h8000_0000, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_STORE_ABS, 5'd0, 5'd6, 5'd0, 32'd0, 13'd8191}, 1'b0, RES_NONE},
    '{'{FUNC_LOAD_ABS, 5'd12, 5'd0, 5'd0, 32'd0, 13'd8191}, 1'b0, RES_NONE},
    // Overwrite a preloaded word, then read it straight back.
    '{'{FUNC_STORE_REL, 5'd0, 5'd6, 5'd7, 32'd15, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_LOAD_ABS, 5'd13, 5'd0, 5'd0, 32'd0, 13'd5}, 1'b0, RES_NONE},
    // Branch not taken, branch taken, then jal into register zero.
    '{'{FUNC_BNE, 5'd0, 5'd1, 5'd3, 32'h7FFF_FFFF, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_BNE, 5'd0, 5'd1, 5'd2, 32'h7FFF_FFFF, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_JAL, 5'd0, 5'd0, 5'd0, 32'h8000_0000, 13'd0}, 1'b0, RES_NONE},
    // Overflow in add and mul, pc wrap through zero.
    '{'{FUNC_ADD, 5'd31, 5'd0, 5'd0, 32'd0, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_MUL, 5'd30, 5'd31, 5'd0, 32'd0, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_BNE, 5'd0, 5'd0, 5'd4, 32'd1, 13'd0}, 1'b0, RES_NONE},
    '{'{FUNC_LOAD_ABS, 5'd0, 5'd0, 5'd0, 32'd0, 13'd4096}, 1'b0, RES_NONE}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [FUNC_W-1:0]     s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  // Architectural state of the local model.
  logic [DATA_W-1:0] arch_regs [REG_COUNT];
  logic [DATA_W-1:0] arch_pc;
  logic [DATA_W-1:0] arch_mem  [MEM_WORDS];

  sce_res_t    retire_q [$];
  typed_slot_t typed_q  [$];
  int          mismatch_count;
  int          burst_left;
  logic        hold_off_req;

  // Last store location, so random loads can read back what was written.
  logic              last_st_rel;
  logic [REG_AW-1:0] last_st_ra;
  logic [DATA_W-1:0] last_st_imm;
  logic [MEM_AW-1:0] last_st_absa;

  simple_cpu_execute_unit_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL simple_cpu_execute_unit_core");
    $finish;
  end

  // Prints one line per mismatch, up to a cap, and always counts it.
  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Executes one instruction on the local state and returns its result.
  function automatic sce_res_t execute_instr(input instr_t ins);
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    logic [DATA_W-1:0] ea;
    logic [DATA_W-1:0] prod;
    sce_res_t          r;
    logic              memop;
    r     = '0;
    memop = 1'b0;
    va    = arch_regs[ins.ra];
    vb    = arch_regs[ins.rb];
    case (ins.func)
      FUNC_ADD: begin
        r.rw   = 1'b1;
        r.wval = va + vb;
      end
      FUNC_SUB: begin
        r.rw   = 1'b1;
        r.wval = va - vb;
      end
      FUNC_MUL: begin
        prod   = va * vb;
        r.rw   = 1'b1;
        r.wval = prod;
      end
      FUNC_LOAD_REL: begin
        ea      = va + ins.imm;
        memop   = 1'b1;
        r.maddr = ea[MEM_AW-1:0];
        r.mval  = arch_mem[r.maddr];
        r.rw    = 1'b1;
        r.wval  = r.mval;
      end
      FUNC_STORE_REL: begin
        ea      = va + ins.imm;
        memop   = 1'b1;
        r.maddr = ea[MEM_AW-1:0];
        r.mval  = vb;
        r.mw    = 1'b1;
        arch_mem[r.maddr] = vb;
      end
      FUNC_LOAD_ABS: begin
        memop   = 1'b1;
        r.maddr = ins.absa;
        r.mval  = arch_mem[r.maddr];
        r.rw    = 1'b1;
        r.wval  = r.mval;
      end
      FUNC_STORE_ABS: begin
        memop   = 1'b1;
        r.maddr = ins.absa;
        r.mval  = va;
        r.mw    = 1'b1;
        arch_mem[r.maddr] = va;
      end
      FUNC_BNE: begin
        if (va != vb) begin
          arch_pc = arch_pc + ins.imm;
        end
      end
      FUNC_JAL: begin
        r.rw    = 1'b1;
        r.wval  = arch_pc;
        arch_pc = arch_pc + ins.imm;
      end
      default: begin
      end
    endcase
    if (r.rw) begin
      arch_regs[ins.rd] = r.wval;
      r.widx = ins.rd;
    end
    if (!memop) begin
      r.maddr = '0;
      r.mval  = '0;
    end
    r.pc = arch_pc;
    return r;
  endfunction

  // Random instruction; a share of loads revisit the most recent store.
  function automatic instr_t rand_instr();
    instr_t ins;
    int     pick;
    pick     = $urandom_range(0, 99);
    ins.rd   = $urandom_range(0, 1) ? REG_AW'($urandom_range(0, 3)) : REG_AW'($urandom);
    ins.ra   = $urandom_range(0, 1) ? REG_AW'($urandom_range(0, 3)) : REG_AW'($urandom);
    ins.rb   = $urandom_range(0, 1) ? REG_AW'($urandom_range(0, 3)) : REG_AW'($urandom);
    case ($urandom_range(0, 5))
      0:       ins.imm = '0;
      1:       ins.imm = DATA_W'($urandom_range(0, 32) - 16);
      2:       ins.imm = 32'h7FFF_FFFF;
      3:       ins.imm = 32'h8000_0000;
      default: ins.imm = $urandom;
    endcase
    case ($urandom_range(0, 2))
      0:       ins.absa = MEM_AW'($urandom_range(0, 15));
      1:       ins.absa = MEM_AW'(4096 + $urandom_range(0, 7));
      default: ins.absa = MEM_AW'($urandom);
    endcase
    if (pick < 60) begin
      ins.func = FUNC_W'($urandom_range(0, 8));
    end else if (pick < 80) begin
      if (last_st_rel) begin
        ins.func = FUNC_LOAD_REL;
        ins.ra   = last_st_ra;
        ins.imm  = last_st_imm;
      end else begin
        ins.func = FUNC_LOAD_ABS;
        ins.absa = last_st_absa;
      end
    end else if (pick < 90) begin
      ins.func = FUNC_W'($urandom_range(FUNC_NOP, FUNC_LAST_ILL));
    end else begin
      ins.func = FUNC_W'($urandom);
    end
    if (ins.func == FUNC_STORE_REL) begin
      last_st_rel = 1'b1;
      last_st_ra  = ins.ra;
      last_st_imm = ins.imm;
    end else if (ins.func == FUNC_STORE_ABS) begin
      last_st_rel  = 1'b0;
      last_st_absa = ins.absa;
    end
    return ins;
  endfunction

  // Idle cycles before the next beat: bursts of random length, random gaps.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 40);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
  endfunction

  // Drives one instruction beat after a gap and waits for it to be taken.
  task automatic offer_beat(input instr_t ins, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = ins.func;
    s_axis_tdata_i  = {4'b0, ins.absa, ins.imm, ins.rb, ins.ra, ins.rd};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Receiver: shifting stall patterns plus one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    m_axis_tready_i = 1'b0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       m_axis_tready_i = 1'b1;
          1:       m_axis_tready_i = 1'($urandom_range(0, 1));
          2:       m_axis_tready_i = ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i = ((phase % 4) != 3);
        endcase
      end
    end
  end

  // Scoreboard: check result beats, then predict newly accepted instructions.
  always @(posedge clk_i) begin
    sce_res_t    got;
    sce_res_t    want;
    instr_t      ins;
    typed_slot_t slot;
    sce_res_t    model;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.pc    = m_axis_tdata_o[31:0];
        got.widx  = m_axis_tdata_o[36:32];
        got.wval  = m_axis_tdata_o[68:37];
        got.maddr = m_axis_tdata_o[81:69];
        got.mval  = m_axis_tdata_o[113:82];
        got.rw    = m_axis_tuser_o[0];
        got.mw    = m_axis_tuser_o[1];
        if (retire_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected, pc", got.pc, '0);
        end else begin
          want = retire_q.pop_front();
          if (got.pc != want.pc) flag_mismatch("pc_value", got.pc, want.pc);
          if (got.rw != want.rw) flag_mismatch("reg_written", 32'(got.rw), 32'(want.rw));
          if (got.widx != want.widx) begin
            flag_mismatch("written_index", 32'(got.widx), 32'(want.widx));
          end
          if (got.wval != want.wval) flag_mismatch("written_value", got.wval, want.wval);
          if (got.mw != want.mw) flag_mismatch("mem_written", 32'(got.mw), 32'(want.mw));
          if (got.maddr != want.maddr) begin
            flag_mismatch("mem_address", 32'(got.maddr), 32'(want.maddr));
          end
          if (got.mval != want.mval) flag_mismatch("mem_value", got.mval, want.mval);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        ins.func = s_axis_tuser_i;
        ins.rd   = s_axis_tdata_i[4:0];
        ins.ra   = s_axis_tdata_i[9:5];
        ins.rb   = s_axis_tdata_i[14:10];
        ins.imm  = s_axis_tdata_i[46:15];
        ins.absa = s_axis_tdata_i[59:47];
        model    = execute_instr(ins);
        slot     = typed_q.pop_front();
        retire_q.push_back(slot.typed ? slot.res : model);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    instr_t ins;
    int     gap;
    int     waited;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    hold_off_req    = 1'b0;
    mismatch_count  = 0;
    burst_left      = 0;
    last_st_rel     = 1'b0;
    last_st_ra      = '0;
    last_st_imm     = '0;
    last_st_absa    = '0;
    arch_pc         = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_mem[PRELOAD_A_ADDR] = PRELOAD_A_VAL;
    arch_mem[PRELOAD_B_ADDR] = PRELOAD_B_VAL;
    arch_mem[PRELOAD_C_ADDR] = PRELOAD_C_VAL;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    for (int i = 0; i < N_DIR; i++) begin
      typed_q.push_back('{DIR_TAB[i].typed, DIR_TAB[i].res});
      offer_beat(DIR_TAB[i].ins, next_gap());
    end

    // Random traffic with one long output hold-off and one full drain.
    for (int i = 0; i < N_RANDOM; i++) begin
      gap = next_gap();
      if (i == HOLD_AT) begin
        hold_off_req = 1'b1;
      end
      if (i >= HOLD_AT && i < HOLD_AT + HOLD_BURST) begin
        gap = 0;
      end
      if (i == DRAIN_AT) begin
        // Withdraw the last beat so it is not taken twice while draining.
        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
        while (retire_q.size() != 0) @(negedge clk_i);
      end
      ins = rand_instr();
      typed_q.push_back('{1'b0, RES_NONE});
      offer_beat(ins, gap);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    // Let outstanding results come back, then watch for strays.
    waited = 0;
    while (retire_q.size() != 0 && waited < END_WAIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (retire_q.size() != 0) begin
      flag_mismatch("results never returned, count", retire_q.size(), '0);
    end
    if (mismatch_count == 0) begin
      $display("PASS simple_cpu_execute_unit_core");
    end else begin
      $display("FAIL simple_cpu_execute_unit_core");
    end
    $finish;
  end

endmodule
